[design/csam_pkg.sv]
// Shared types, codes and arithmetic helpers for the crystal symmetry atom mapper.
// No dependencies; the design files refer to this package by scoped names, the testbench files import it.
`timescale 1ns / 1ps
`default_nettype none

package csam_pkg;

    localparam int FRAC_W     = 24;
    localparam int ROT_W      = 27;
    localparam int TOL_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MAT_W      = 22;
    localparam int SLOT_W     = 6;
    localparam int SPEC_W     = 8;
    localparam int ORDER_W    = 7;

    localparam int MAX_ATOMS_DEF = 64;
    localparam int MAX_ORDER_DEF = 12;

    // request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_MAP   = 2'd1;
    localparam logic [1:0] REQ_ORDER = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_MATCH  = 2'd1;
    localparam logic [1:0] STAT_SPECIES   = 2'd2;
    localparam logic [1:0] STAT_ORDER_MAX = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 3'd5;

    localparam logic [ROT_W-1:0] ROT_RESET = 27'd16843009;
    localparam logic [TOL_W-1:0] TOL_RESET = 48'd281474977;
    // identity test is |v|^2 <= 281474977, done as a strict compare
    localparam logic [TOL_W-1:0] ORDER_TOL_LIMIT = 48'd281474978;
    localparam logic signed [MAT_W-1:0] MAT_CLAMP = 22'sd1048576;

    typedef logic [FRAC_W-1:0] frac_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [SLOT_W-1:0]  atom_slot;
        logic signed [27:0] coord_x;
        logic signed [27:0] coord_y;
        logic signed [27:0] coord_z;
        logic [SPEC_W-1:0]  species_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]         status_code;
        logic [SLOT_W-1:0]  matched_slot;
        logic [ORDER_W-1:0] op_order;
    } res_t;

    // fractional parts only: all distance math is modulo one lattice period
    typedef struct packed {
        frac_t x;
        frac_t y;
        frac_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t             pos;
        logic [SPEC_W-1:0] species;
    } atom_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SPEC_W-1:0] species;
    } tag_t;

    typedef struct packed {
        logic valid;
        logic hit;
        tag_t tag;
    } dist_res_t;

    function automatic vec3_t vec_add(input vec3_t a, input vec3_t b);
        vec3_t r;
        r.x = a.x + b.x;
        r.y = a.y + b.y;
        r.z = a.z + b.z;
        return r;
    endfunction

    function automatic vec3_t vec_sub(input vec3_t a, input vec3_t b);
        vec3_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    // R*q modulo 2^FRAC_W; low bits of a product do not depend on signedness
    function automatic vec3_t rot_apply(input logic [ROT_W-1:0] rot, input vec3_t q);
        vec3_t r;
        frac_t qv [3];
        frac_t acc [3];
        qv[0] = q.x;
        qv[1] = q.y;
        qv[2] = q.z;
        for (int i = 0; i < 3; i++) begin
            acc[i] = '0;
            for (int k = 0; k < 3; k++) begin
                acc[i] = acc[i] + frac_t'(signed'(rot[3*(3*i+k) +: 3])) * qv[k];
            end
        end
        r.x = acc[0];
        r.y = acc[1];
        r.z = acc[2];
        return r;
    endfunction

endpackage

`default_nettype wire

[design/csam_store.sv]
// Atom table: one write port, one read port with registered read data.
// Depends on csam_pkg (atom_t).
`timescale 1ns / 1ps
`default_nettype none

module csam_store #(
    parameter int DEPTH = csam_pkg::MAX_ATOMS_DEF,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire csam_pkg::atom_t  wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output csam_pkg::atom_t       rd_data
);

    csam_pkg::atom_t mem [DEPTH];
    csam_pkg::atom_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/csam_dist.sv]
// Squared-distance unit: registered squares, then sum and compare to a limit.
// Depends on csam_pkg (vec3_t, tag_t, dist_res_t).
`timescale 1ns / 1ps
`default_nettype none

module csam_dist (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    input  wire csam_pkg::vec3_t                in_vec,
    input  wire csam_pkg::tag_t                 in_tag,
    input  wire logic [csam_pkg::TOL_W-1:0]     limit,
    output csam_pkg::dist_res_t                 res
);

    localparam int PROD_W = 2 * csam_pkg::FRAC_W;
    localparam int SQ_W   = PROD_W - 1;   // |d| <= 2^23, so d^2 <= 2^46

    logic signed [csam_pkg::FRAC_W-1:0] dv [3];
    logic signed [PROD_W-1:0]           prod [3];
    logic [SQ_W-1:0]                    sq_next [3];
    logic [SQ_W-1:0]                    sq_reg [3];
    logic                               valid_reg;
    csam_pkg::tag_t                     tag_reg;
    logic [csam_pkg::TOL_W-1:0]         sum;

    always_comb begin
        dv[0] = signed'(in_vec.x);
        dv[1] = signed'(in_vec.y);
        dv[2] = signed'(in_vec.z);
        for (int k = 0; k < 3; k++) begin
            prod[k]    = PROD_W'(dv[k]) * PROD_W'(dv[k]);
            sq_next[k] = prod[k][SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= sq_next[k];
        end
        tag_reg <= in_tag;
    end

    assign sum = csam_pkg::TOL_W'(sq_reg[0]) + csam_pkg::TOL_W'(sq_reg[1])
               + csam_pkg::TOL_W'(sq_reg[2]);

    assign res.valid = valid_reg;
    assign res.hit   = sum < limit;
    assign res.tag   = tag_reg;

endmodule

`default_nettype wire

[design/csam_order.sv]
// Power iteration of the symmetry operation: clamped matrix product and
// wrapped translation, one step per strobe. Depends on csam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csam_order (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          init,
    input  wire logic                          step,
    input  wire logic [csam_pkg::ROT_W-1:0]    rot,
    input  wire csam_pkg::vec3_t               shift,
    output csam_pkg::vec3_t                    v,
    output logic                               mat_is_identity
);

    localparam int MW    = csam_pkg::MAT_W;
    localparam int SUM_W = MW + 5;
    localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(csam_pkg::MAT_CLAMP);
    localparam logic signed [SUM_W-1:0] CLAMP_LO = -CLAMP_HI;

    logic signed [MW-1:0]    mat_reg  [9];
    logic signed [MW-1:0]    mat_next [9];
    logic signed [SUM_W-1:0] acc      [9];
    logic [8:0]              clip;
    csam_pkg::vec3_t         v_reg;
    csam_pkg::vec3_t         v_next;
    logic                    diverged_reg;
    logic                    id_match;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                acc[3*i+c] = '0;
                for (int k = 0; k < 3; k++) begin
                    acc[3*i+c] = acc[3*i+c]
                               + SUM_W'(signed'(rot[3*(3*i+k) +: 3]))
                               * SUM_W'(mat_reg[3*k+c]);
                end
            end
        end
        for (int e = 0; e < 9; e++) begin
            clip[e] = 1'b0;
            if (acc[e] > CLAMP_HI) begin
                mat_next[e] = csam_pkg::MAT_CLAMP;
                clip[e]     = 1'b1;
            end else if (acc[e] < CLAMP_LO) begin
                mat_next[e] = -csam_pkg::MAT_CLAMP;
                clip[e]     = 1'b1;
            end else begin
                mat_next[e] = MW'(acc[e]);
            end
        end
        v_next = csam_pkg::rot_apply(rot, csam_pkg::vec_add(v_reg, shift));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diverged_reg <= 1'b0;
        end else if (init) begin
            diverged_reg <= 1'b0;
        end else if (step) begin
            diverged_reg <= diverged_reg | (|clip);
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            for (int e = 0; e < 9; e++) begin
                mat_reg[e] <= (e == 0 || e == 4 || e == 8) ? MW'(1) : '0;
            end
            v_reg <= '0;
        end else if (step) begin
            for (int e = 0; e < 9; e++) begin
                mat_reg[e] <= mat_next[e];
            end
            v_reg <= v_next;
        end
    end

    always_comb begin
        id_match = 1'b1;
        for (int e = 0; e < 9; e++) begin
            if (mat_reg[e] != ((e == 0 || e == 4 || e == 8) ? MW'(1) : MW'(0))) begin
                id_match = 1'b0;
            end
        end
    end

    assign mat_is_identity = id_match && !diverged_reg;
    assign v               = v_reg;

endmodule

`default_nettype wire

[design/crystal_symmetry_atom_mapper.sv]
// Flow: a load, or a map of an out-of-range slot, goes straight to the result handoff;
//   a map of a valid slot reads its source atom, then scans the table in index order.
// Order request: power steps until the identity is reached, up to MAX_ORDER steps.
// Requests: one beat in flight; the single table read port paces map scans.
// Reset (aresetn low, synchronous): config registers to defaults, FSM idle,
//   no result pending. The atom table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module crystal_symmetry_atom_mapper #(
    parameter int MAX_ATOMS = csam_pkg::MAX_ATOMS_DEF,
    parameter int MAX_ORDER = csam_pkg::MAX_ORDER_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [csam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csam_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire csam_pkg::req_t                    s_data,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output csam_pkg::res_t                         m_data
);

    // table address and counter widths
    localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = ($clog2(MAX_ATOMS + 1) > 7) ? $clog2(MAX_ATOMS + 1) : 7;
    localparam int ORD_W = $clog2(MAX_ORDER + 1);

    // control states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAP_HEAD = 3'd1;  // source atom read back, map it
    localparam logic [2:0] S_MAP_SCAN = 3'd2;  // stream table through dist unit
    localparam logic [2:0] S_ORD_STEP = 3'd3;  // one power step
    localparam logic [2:0] S_ORD_CHK1 = 3'd4;  // squares of translation
    localparam logic [2:0] S_ORD_CHK2 = 3'd5;  // identity decision
    localparam logic [2:0] S_FIN      = 3'd6;  // hand result to output register

    logic [2:0] state_reg, state_next;

    // ---------------------------------------------------------------
    // Configuration registers. Only the low fraction bits of the shift
    // matter since every coordinate is reduced modulo one lattice period.
    // ---------------------------------------------------------------
    logic [csam_pkg::ROT_W-1:0] rot_reg;
    csam_pkg::vec3_t            shift_reg;
    logic [6:0]                 acnt_reg;
    logic [csam_pkg::TOL_W-1:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg   <= csam_pkg::ROT_RESET;
            shift_reg <= '0;
            acnt_reg  <= '0;
            tol_reg   <= csam_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                csam_pkg::CFG_ROT:     rot_reg     <= cfg_wr_data[csam_pkg::ROT_W-1:0];
                csam_pkg::CFG_SHIFT_X: shift_reg.x <= cfg_wr_data[csam_pkg::FRAC_W-1:0];
                csam_pkg::CFG_SHIFT_Y: shift_reg.y <= cfg_wr_data[csam_pkg::FRAC_W-1:0];
                csam_pkg::CFG_SHIFT_Z: shift_reg.z <= cfg_wr_data[csam_pkg::FRAC_W-1:0];
                csam_pkg::CFG_COUNT:   acnt_reg    <= cfg_wr_data[6:0];
                csam_pkg::CFG_TOL:     tol_reg     <= cfg_wr_data[csam_pkg::TOL_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // searched count saturates at the table depth
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] acnt_ext;
    assign acnt_ext = CNT_W'(acnt_reg);
    assign n_eff    = (acnt_ext > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : acnt_ext;

    // ---------------------------------------------------------------
    // Request handshake
    // ---------------------------------------------------------------
    logic             accept;
    logic [CNT_W-1:0] slot_ext;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign slot_ext = CNT_W'(s_data.atom_slot);

    // ---------------------------------------------------------------
    // Atom table. The first read of a map beat fetches the source atom;
    // after that one entry a cycle is issued in index order.
    // ---------------------------------------------------------------
    logic               wr_en, rd_en, scan_issue;
    logic [AW-1:0]      rd_addr;
    csam_pkg::atom_t    wr_atom, rd_atom;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               rdv_reg;            // rd_atom holds a scan entry
    logic [csam_pkg::SLOT_W-1:0] rd_slot_reg, rd_slot_next;

    assign scan_issue = (state_reg == S_MAP_HEAD || state_reg == S_MAP_SCAN)
                     && (iss_reg < n_eff);
    assign wr_en      = accept && (s_data.req_type == csam_pkg::REQ_LOAD)
                     && (slot_ext < CNT_W'(MAX_ATOMS));
    assign rd_en      = (accept && (s_data.req_type == csam_pkg::REQ_MAP)) || scan_issue;
    assign rd_addr    = scan_issue ? iss_reg[AW-1:0] : AW'(s_data.atom_slot);

    assign wr_atom.pos.x   = s_data.coord_x[csam_pkg::FRAC_W-1:0];
    assign wr_atom.pos.y   = s_data.coord_y[csam_pkg::FRAC_W-1:0];
    assign wr_atom.pos.z   = s_data.coord_z[csam_pkg::FRAC_W-1:0];
    assign wr_atom.species = s_data.species_tag;

    csam_store #(
        .DEPTH (MAX_ATOMS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.atom_slot)),
        .wr_data (wr_atom),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_atom)
    );

    // ---------------------------------------------------------------
    // Order iteration unit
    // ---------------------------------------------------------------
    logic            ord_init, ord_step, ord_ident;
    csam_pkg::vec3_t ord_v;

    csam_order u_order (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .init            (ord_init),
        .step            (ord_step),
        .rot             (rot_reg),
        .shift           (shift_reg),
        .v               (ord_v),
        .mat_is_identity (ord_ident)
    );

    // ---------------------------------------------------------------
    // Distance unit, shared: map scan feeds wrapped differences, the
    // order check feeds the accumulated translation.
    // ---------------------------------------------------------------
    csam_pkg::vec3_t            map_reg, map_next;    // R(p+t) mod 1
    logic [csam_pkg::SPEC_W-1:0] sp_reg, sp_next;      // source species
    logic                       din_valid;
    csam_pkg::vec3_t            din_vec;
    csam_pkg::tag_t             din_tag;
    logic [csam_pkg::TOL_W-1:0] limit;
    csam_pkg::dist_res_t        dres;

    assign din_valid = (state_reg == S_MAP_SCAN && rdv_reg) || (state_reg == S_ORD_CHK1);
    assign din_vec   = (state_reg == S_ORD_CHK1) ? ord_v
                                                 : csam_pkg::vec_sub(map_reg, rd_atom.pos);
    assign din_tag.slot    = rd_slot_reg;
    assign din_tag.species = rd_atom.species;
    assign limit     = (state_reg == S_ORD_CHK2) ? csam_pkg::ORDER_TOL_LIMIT : tol_reg;

    csam_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (din_valid),
        .in_vec   (din_vec),
        .in_tag   (din_tag),
        .limit    (limit),
        .res      (dres)
    );

    // ---------------------------------------------------------------
    // Control FSM
    // ---------------------------------------------------------------
    csam_pkg::res_t   res_reg, res_next;
    logic [CNT_W-1:0] ret_reg, ret_next;     // scan entries retired without a hit
    logic [ORD_W-1:0] step_reg, step_next;
    logic             out_load;

    assign out_load     = (state_reg == S_FIN) && (!m_valid || m_ready);
    assign rd_slot_next = scan_issue ? csam_pkg::SLOT_W'(iss_reg) : rd_slot_reg;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        iss_next   = scan_issue ? (iss_reg + CNT_W'(1)) : iss_reg;
        ret_next   = ret_reg;
        step_next  = step_reg;
        map_next   = map_reg;
        sp_next    = sp_reg;
        ord_init   = 1'b0;
        ord_step   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next  = '0;
                    iss_next  = '0;
                    ret_next  = '0;
                    step_next = '0;
                    unique case (s_data.req_type)
                        csam_pkg::REQ_LOAD: state_next = S_FIN;
                        csam_pkg::REQ_MAP: begin
                            if (slot_ext >= n_eff) begin
                                res_next.status_code = csam_pkg::STAT_NO_MATCH;
                                state_next           = S_FIN;
                            end else begin
                                state_next = S_MAP_HEAD;
                            end
                        end
                        csam_pkg::REQ_ORDER: begin
                            ord_init   = 1'b1;
                            state_next = S_ORD_STEP;
                        end
                        default: state_next = S_FIN;  // unused type, all-zero result
                    endcase
                end
            end
            S_MAP_HEAD: begin
                map_next   = csam_pkg::rot_apply(rot_reg,
                                 csam_pkg::vec_add(rd_atom.pos, shift_reg));
                sp_next    = rd_atom.species;
                state_next = S_MAP_SCAN;
            end
            S_MAP_SCAN: begin
                // results retire in index order, so the first hit wins
                if (dres.valid) begin
                    if (dres.hit) begin
                        res_next.status_code  = (sp_reg != dres.tag.species)
                                              ? csam_pkg::STAT_SPECIES : csam_pkg::STAT_OK;
                        res_next.matched_slot = dres.tag.slot;
                        state_next            = S_FIN;
                    end else begin
                        ret_next = ret_reg + CNT_W'(1);
                        if ((ret_reg + CNT_W'(1)) == n_eff) begin
                            res_next.status_code = csam_pkg::STAT_NO_MATCH;
                            state_next           = S_FIN;
                        end
                    end
                end
            end
            S_ORD_STEP: begin
                ord_step   = 1'b1;
                step_next  = step_reg + ORD_W'(1);
                state_next = S_ORD_CHK1;
            end
            S_ORD_CHK1: begin
                state_next = S_ORD_CHK2;
            end
            S_ORD_CHK2: begin
                if (dres.hit && ord_ident) begin
                    res_next.op_order = csam_pkg::ORDER_W'(step_reg);
                    state_next        = S_FIN;
                end else if (step_reg == ORD_W'(MAX_ORDER)) begin
                    res_next.status_code = csam_pkg::STAT_ORDER_MAX;
                    state_next           = S_FIN;
                end else begin
                    state_next = S_ORD_STEP;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rdv_reg   <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= scan_issue;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg     <= res_next;
        iss_reg     <= iss_next;
        ret_reg     <= ret_next;
        step_reg    <= step_next;
        map_reg     <= map_next;
        sp_reg      <= sp_next;
        rd_slot_reg <= rd_slot_next;
        if (out_load) begin
            m_data <= res_reg;
        end
    end

`ifndef SYNTHESIS
    // a load goes straight to result handoff
    a_load_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == csam_pkg::REQ_LOAD) |=> (state_reg == S_FIN))
        else $error("load beat did not go to result handoff");

    // scan never issues past the searched count
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAP_SCAN) |-> (iss_reg <= n_eff))
        else $error("scan issued beyond searched count");

    // retired entries stay behind the searched count while scanning
    a_retire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAP_SCAN) |-> (ret_reg < n_eff))
        else $error("scan retired more entries than searched");

    // order check always sees a fresh distance result and a step in range
    a_order_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ORD_CHK2) |-> (dres.valid && step_reg != '0
                                      && step_reg <= ORD_W'(MAX_ORDER)))
        else $error("order check out of step");
`endif

endmodule

`default_nettype wire

[tb/sv/csam_answer_checker.sv]
// Answer checker for the crystal symmetry atom mapper testbench: snoops the config
// port and both beat channels, predicts each answer and compares it field by field.
// Depends on csam_pkg for the beat structs, request/status codes and register indexes.
`timescale 1ns / 1ps

module csam_answer_checker
    import csam_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire req_t                  s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire res_t                  m_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int     TABLE_DEPTH  = MAX_ATOMS_DEF;
    localparam int     ORDER_STEPS  = MAX_ORDER_DEF;
    localparam longint IDENTITY_TOL = 64'sd281474977;
    localparam longint ENTRY_CLAMP  = 64'sd1048576;

    // mirrored atom table and operation registers
    longint            tbl_x    [TABLE_DEPTH];
    longint            tbl_y    [TABLE_DEPTH];
    longint            tbl_z    [TABLE_DEPTH];
    logic [SPEC_W-1:0] tbl_spec [TABLE_DEPTH];
    logic [ROT_W-1:0]  rot;
    longint            shift [3];
    int                searched;
    logic [TOL_W-1:0]  tol;

    res_t answers [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic longint rot_entry(input int k);
        return longint'(signed'(rot[3*k +: 3]));
    endfunction

    // keep the fractional part, centered on zero
    function automatic longint frac_wrap(input longint d);
        logic signed [FRAC_W-1:0] f;
        f = d[FRAC_W-1:0];
        return longint'(f);
    endfunction

    function automatic longint norm_sq(input longint a, input longint b, input longint c);
        return a * a + b * b + c * c;
    endfunction

    function automatic res_t map_answer(input int slot);
        res_t   a;
        longint q [3];
        longint m [3];
        longint d0, d1, d2;
        a = '0;
        if (slot >= searched) begin
            a.status_code = STAT_NO_MATCH;
            return a;
        end
        q[0] = tbl_x[slot] + shift[0];
        q[1] = tbl_y[slot] + shift[1];
        q[2] = tbl_z[slot] + shift[2];
        for (int i = 0; i < 3; i++)
            m[i] = rot_entry(3*i) * q[0] + rot_entry(3*i+1) * q[1] + rot_entry(3*i+2) * q[2];
        for (int j = 0; j < searched; j++) begin
            d0 = frac_wrap(m[0] - tbl_x[j]);
            d1 = frac_wrap(m[1] - tbl_y[j]);
            d2 = frac_wrap(m[2] - tbl_z[j]);
            if (norm_sq(d0, d1, d2) < longint'({16'd0, tol})) begin
                a.matched_slot = SLOT_W'(j);
                a.status_code  = (tbl_spec[slot] != tbl_spec[j]) ? STAT_SPECIES : STAT_OK;
                return a;
            end
        end
        a.status_code = STAT_NO_MATCH;
        return a;
    endfunction

    // smallest n with S^n = identity modulo lattice translations
    function automatic res_t order_answer();
        res_t   a;
        longint mat [9];
        longint nm  [9];
        longint v   [3];
        longint nv  [3];
        longint q   [3];
        longint s;
        bit     diverged;
        bit     ident;
        a = '0;
        mat = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        v = '{0, 0, 0};
        diverged = 1'b0;
        for (int step = 0; step < ORDER_STEPS; step++) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    s = 0;
                    for (int k = 0; k < 3; k++)
                        s += rot_entry(3*i+k) * mat[3*k+c];
                    if (s > ENTRY_CLAMP) begin
                        s = ENTRY_CLAMP;
                        diverged = 1'b1;
                    end
                    if (s < -ENTRY_CLAMP) begin
                        s = -ENTRY_CLAMP;
                        diverged = 1'b1;
                    end
                    nm[3*i+c] = s;
                end
            end
            for (int i = 0; i < 3; i++)
                q[i] = v[i] + shift[i];
            for (int i = 0; i < 3; i++)
                nv[i] = frac_wrap(rot_entry(3*i) * q[0] + rot_entry(3*i+1) * q[1]
                                  + rot_entry(3*i+2) * q[2]);
            ident = !diverged;
            for (int i = 0; i < 9; i++)
                if (nm[i] != ((i % 4 == 0) ? 1 : 0))
                    ident = 1'b0;
            if (norm_sq(nv[0], nv[1], nv[2]) > IDENTITY_TOL)
                ident = 1'b0;
            if (ident) begin
                a.op_order = ORDER_W'(step + 1);
                return a;
            end
            mat = nm;
            v = nv;
        end
        a.status_code = STAT_ORDER_MAX;
        return a;
    endfunction

    function automatic res_t answer_for(input req_t r);
        res_t a;
        a = '0;
        case (r.req_type)
            REQ_LOAD: begin
                tbl_x[r.atom_slot]    = longint'(signed'(r.coord_x));
                tbl_y[r.atom_slot]    = longint'(signed'(r.coord_y));
                tbl_z[r.atom_slot]    = longint'(signed'(r.coord_z));
                tbl_spec[r.atom_slot] = r.species_tag;
            end
            REQ_MAP:   a = map_answer(int'(r.atom_slot));
            REQ_ORDER: a = order_answer();
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            rot = ROT_RESET;
            shift = '{0, 0, 0};
            searched = 0;
            tol = TOL_RESET;
            answers.delete();
            mismatches = 0;
            outstanding = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROT:     rot = cfg_wr_data[ROT_W-1:0];
                    CFG_SHIFT_X: shift[0] = longint'(signed'(cfg_wr_data[25:0]));
                    CFG_SHIFT_Y: shift[1] = longint'(signed'(cfg_wr_data[25:0]));
                    CFG_SHIFT_Z: shift[2] = longint'(signed'(cfg_wr_data[25:0]));
                    CFG_COUNT:   searched = (int'(cfg_wr_data[6:0]) > TABLE_DEPTH) ?
                                            TABLE_DEPTH : int'(cfg_wr_data[6:0]);
                    CFG_TOL:     tol = cfg_wr_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (answers.size() == 0) begin
                    flag_mismatch("result beat with nothing pending", 32'(got.status_code), 0);
                end else begin
                    want = answers.pop_front();
                    if (got.status_code !== want.status_code)
                        flag_mismatch("status_code", 32'(got.status_code),
                                      32'(want.status_code));
                    if (got.matched_slot !== want.matched_slot)
                        flag_mismatch("matched_slot", 32'(got.matched_slot),
                                      32'(want.matched_slot));
                    if (got.op_order !== want.op_order)
                        flag_mismatch("op_order", 32'(got.op_order), 32'(want.op_order));
                end
            end
            if (s_valid && s_ready)
                answers.push_back(answer_for(s_data));
            outstanding = answers.size();
        end
    end

endmodule

[tb/sv/crystal_symmetry_atom_mapper_tb.sv]
// Top of the crystal symmetry atom mapper testbench: clock, reset, config writes and
// request/result beats with random idling; csam_answer_checker judges every answer.
// Depends on csam_pkg, crystal_symmetry_atom_mapper and csam_answer_checker.
`timescale 1ns / 1ps

module crystal_symmetry_atom_mapper_tb;
    import csam_pkg::*;

    // request code the block must answer with all-zero fields
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // selectors into the table of crystallographic point operations
    localparam int OP_IDENTITY  = 0;
    localparam int OP_INVERSION = 1;
    localparam int OP_SIXFOLD   = 6;

    localparam longint ONE_CELL      = 64'sd16777216;
    localparam int     RANDOM_ITEMS  = 1550;
    // beats in this window go with no idling on either side
    localparam int     CALM_FROM     = 700;
    localparam int     CALM_TO       = 950;
    localparam int     IDLE_PCT      = 34;
    localparam int     DRAIN_CYCLES  = 80;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    req_t                  s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    res_t                  m_data;
    int                    mismatches;
    int                    outstanding;

    // what the stimulus knows of the current setup
    logic [ROT_W-1:0] cur_rot;
    longint           cur_t [3];
    int               n_eff;
    logic [63:0]      loaded = '0;   // slots written since reset
    int               sent   = 0;
    bit               calm   = 1'b0;

    crystal_symmetry_atom_mapper dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    csam_answer_checker answer_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always #5 aclk = ~aclk;

    // result side backpressure, decided once per cycle at the falling edge
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // hard stop in case the block hangs
    initial begin
        #12_000_000;
        $display("crystal_symmetry_atom_mapper_tb: done, errors");
        $finish;
    end

    function automatic logic [ROT_W-1:0] pack_rot(input int m0, input int m1, input int m2,
                                                  input int m3, input int m4, input int m5,
                                                  input int m6, input int m7, input int m8);
        logic [ROT_W-1:0] r;
        r[2:0]   = 3'(m0);
        r[5:3]   = 3'(m1);
        r[8:6]   = 3'(m2);
        r[11:9]  = 3'(m3);
        r[14:12] = 3'(m4);
        r[17:15] = 3'(m5);
        r[20:18] = 3'(m6);
        r[23:21] = 3'(m7);
        r[26:24] = 3'(m8);
        return r;
    endfunction

    // point operations of real space groups: these give finite orders
    function automatic logic [ROT_W-1:0] crystal_op(input int sel);
        case (sel)
            OP_IDENTITY:  return pack_rot( 1,  0,  0,   0,  1,  0,   0,  0,  1);
            OP_INVERSION: return pack_rot(-1,  0,  0,   0, -1,  0,   0,  0, -1);
            2:            return pack_rot(-1,  0,  0,   0, -1,  0,   0,  0,  1); // 2-fold z
            3:            return pack_rot( 1,  0,  0,   0,  1,  0,   0,  0, -1); // mirror z
            4:            return pack_rot( 0,  0,  1,   1,  0,  0,   0,  1,  0); // 3-fold diag
            5:            return pack_rot( 0, -1,  0,   1,  0,  0,   0,  0,  1); // 4-fold z
            OP_SIXFOLD:   return pack_rot( 1, -1,  0,   1,  0,  0,   0,  0,  1); // hex 6-fold
            default:      return pack_rot( 0,  0, -1,  -1,  0,  0,   0, -1,  0); // -3
        endcase
    endfunction

    // translation that is a simple lattice fraction, with 1/13 to overrun the order limit
    function automatic longint lattice_shift();
        int     den;
        int     num;
        longint v;
        case ($urandom_range(6))
            0:       den = 1;
            1:       den = 2;
            2:       den = 3;
            3:       den = 4;
            4:       den = 6;
            5:       den = 12;
            default: den = 13;
        endcase
        num = $urandom_range(den - 1);
        v = (longint'(num) * ONE_CELL) / den;
        if ($urandom_range(1))
            v -= ONE_CELL;
        return v;
    endfunction

    function automatic longint wide_shift();
        logic signed [25:0] w;
        w = 26'($urandom);
        return longint'(w);
    endfunction

    function automatic req_t random_req(input logic [1:0] kind);
        req_t r;
        r.req_type    = kind;
        r.atom_slot   = 6'($urandom);
        r.coord_x     = 28'($urandom);
        r.coord_y     = 28'($urandom);
        r.coord_z     = 28'($urandom);
        r.species_tag = 8'($urandom);
        return r;
    endfunction

    function automatic req_t load_req(input int slot, input longint x, input longint y,
                                      input longint z, input logic [SPEC_W-1:0] spec);
        req_t r;
        r.req_type    = REQ_LOAD;
        r.atom_slot   = 6'(slot);
        r.coord_x     = 28'(x);
        r.coord_y     = 28'(y);
        r.coord_z     = 28'(z);
        r.species_tag = spec;
        return r;
    endfunction

    function automatic req_t map_req(input int slot);
        req_t r;
        r = random_req(REQ_MAP);
        r.atom_slot = 6'(slot);
        return r;
    endfunction

    // one register write; enable drops at the next falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Drive one request beat. Idle cycles go in front of it at random; valid is only
    // dropped at a falling edge where it is not raised again, and then holds to accept.
    task automatic push_request(input req_t r);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        if (r.req_type == REQ_LOAD)
            loaded[r.atom_slot] = 1'b1;
        sent++;
        calm = (sent >= CALM_FROM) && (sent < CALM_TO);
    endtask

    // Let every answer come back before the setup changes. Each request gets exactly
    // one answer, so a short pause after the last one covers the block's wind-down.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic program_op(input logic [ROT_W-1:0] rot, input longint tx, input longint ty,
                              input longint tz);
        cfg_write(CFG_ROT, CFG_DATA_W'(rot));
        cfg_write(CFG_SHIFT_X, CFG_DATA_W'(tx));   // upper bits carry the sign
        cfg_write(CFG_SHIFT_Y, CFG_DATA_W'(ty));
        cfg_write(CFG_SHIFT_Z, CFG_DATA_W'(tz));
        cur_rot = rot;
        cur_t[0] = tx;
        cur_t[1] = ty;
        cur_t[2] = tz;
    endtask

    // Set the searched count and tolerance, then load any slot a scan could reach
    // that was never written: the table holds no defined data until loaded.
    task automatic program_search(input int count, input logic [TOL_W-1:0] tol);
        cfg_write(CFG_COUNT, CFG_DATA_W'(count));
        cfg_write(CFG_TOL, CFG_DATA_W'(tol));
        n_eff = (count > MAX_ATOMS_DEF) ? MAX_ATOMS_DEF : count;
        for (int s = 0; s < n_eff; s++)
            if (!loaded[s])
                push_request(load_req(s, longint'(signed'(28'($urandom))),
                                      longint'(signed'(28'($urandom))),
                                      longint'(signed'(28'($urandom))), 8'($urandom)));
    endtask

    // Load an atom, load its image under the current operation (plus a whole-cell offset
    // and some jitter) into a random slot, possibly the same, then map the first one.
    // Without this, random positions almost never match and no scan would stop early.
    task automatic orbit_pair();
        int                       src;
        int                       dst;
        longint                   base [3];
        longint                   img  [3];
        longint                   acc;
        longint                   nudge;
        logic signed [FRAC_W-1:0] frac;
        req_t                     r;
        src = $urandom_range(n_eff - 1);
        dst = $urandom_range(n_eff - 1);
        for (int i = 0; i < 3; i++)
            base[i] = longint'(signed'(28'($urandom)));
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += longint'(signed'(cur_rot[3*(3*i+k) +: 3])) * (base[k] + cur_t[k]);
            frac = acc[FRAC_W-1:0];
            case ($urandom_range(3))
                0:       nudge = 0;
                1:       nudge = $urandom_range(255);
                2:       nudge = $urandom_range(16384);
                default: nudge = $urandom_range(1 << 20, 1 << 15);
            endcase
            if ($urandom_range(1))
                nudge = -nudge;
            img[i] = longint'(frac) + (longint'($urandom_range(14)) - 7) * ONE_CELL + nudge;
        end
        r = load_req(src, base[0], base[1], base[2], 8'($urandom));
        push_request(r);
        r.atom_slot = 6'(dst);
        r.coord_x   = 28'(img[0]);
        r.coord_y   = 28'(img[1]);
        r.coord_z   = 28'(img[2]);
        if ($urandom_range(4) == 0)
            r.species_tag = 8'($urandom);   // same site, other species
        push_request(r);
        push_request(map_req(src));
    endtask

    initial begin
        req_t             r;
        int               count;
        int               len;
        int               pick;
        int               phase;
        logic [TOL_W-1:0] tol;

        // synchronous reset, released at a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        cur_rot = ROT_RESET;
        cur_t = '{0, 0, 0};
        n_eff = 0;

        // ---- directed part ----
        // Reset setup: nothing searched, so any map is out of range. The reset
        // rotation is singular and can never come back to the identity.
        push_request(map_req(0));
        push_request(random_req(REQ_ORDER));
        r = '1;
        r.req_type = REQ_UNUSED;            // unused code, every other bit high
        push_request(r);
        // coordinate extremes and species extremes
        push_request(load_req(0, 64'sd134217727, 64'sd134217727, 64'sd134217727, 8'hFF));
        push_request(load_req(1, -64'sd134217728, -64'sd134217728, -64'sd134217728, 8'h00));
        push_request(load_req(2, 0, 0, 0, 8'h5A));
        push_request(load_req(63, 64'sd5592405, -64'sd11184811, 64'sd87654321, 8'hA5));

        // Identity: slot 0 finds itself; slot 1 sits one fraction step off slot 0
        // and hits it first with another species; slot 63 is past the count.
        settle();
        program_op(crystal_op(OP_IDENTITY), 0, 0, 0);
        program_search(3, TOL_RESET);
        push_request(map_req(0));
        push_request(map_req(1));
        push_request(map_req(2));
        push_request(map_req(63));
        push_request(random_req(REQ_ORDER));        // order one

        // inversion with translation extremes and a zero tolerance: nothing matches
        settle();
        program_op(crystal_op(OP_INVERSION), 64'sd33554431, -64'sd33554432, 0);
        program_search(3, '0);
        push_request(map_req(0));
        push_request(random_req(REQ_ORDER));

        // all entries -1, widest tolerance: the first atom always matches
        settle();
        program_op('1, 0, 0, 0);
        program_search(3, '1);
        push_request(map_req(1));
        push_request(random_req(REQ_ORDER));

        // zero matrix
        settle();
        program_op('0, 0, 0, 0);
        push_request(map_req(2));
        push_request(random_req(REQ_ORDER));

        // 6-fold screw of 1/12 has order twelve; 1/13 runs past the limit
        settle();
        program_op(crystal_op(OP_SIXFOLD), 0, 0, ONE_CELL / 12);
        push_request(random_req(REQ_ORDER));
        settle();
        program_op(crystal_op(OP_SIXFOLD), 0, 0, ONE_CELL / 13);
        push_request(random_req(REQ_ORDER));

        // -4 on the diagonal: the matrix entries hit the clamp
        settle();
        program_op(pack_rot(-4, 0, 0, 0, -4, 0, 0, 0, -4), 0, 0, 0);
        push_request(random_req(REQ_ORDER));

        // ---- random part: one setup per phase, then a burst of requests ----
        phase = 0;
        while (sent < RANDOM_ITEMS + 25) begin
            settle();
            if ($urandom_range(9) < 7)
                program_op(crystal_op($urandom_range(7)), lattice_shift(), lattice_shift(),
                           lattice_shift());
            else
                program_op(27'($urandom), wide_shift(), wide_shift(), wide_shift());

            case ($urandom_range(9))
                0:       count = 0;
                1:       count = $urandom_range(127, 65);   // saturates at the table size
                2:       count = MAX_ATOMS_DEF;
                3, 4:    count = $urandom_range(63, 17);
                default: count = $urandom_range(16, 1);
            endcase
            case ($urandom_range(9))
                0:       tol = '0;
                1:       tol = '1;
                2:       tol = {16'($urandom), 32'($urandom)};
                3:       tol = TOL_RESET;
                default: tol = TOL_W'($urandom) >> $urandom_range(12);
            endcase
            // first phase fills the whole table and sets a count past its end
            if (phase == 0) begin
                count = 127;
                tol = '1;
            end
            program_search(count, tol);

            len = $urandom_range(60, 20);
            repeat (len) begin
                pick = $urandom_range(99);
                if (pick < 35 && n_eff > 0)
                    orbit_pair();
                else if (pick < 65)
                    push_request(map_req((n_eff > 0 && $urandom_range(9) < 8) ?
                                         $urandom_range(n_eff - 1) : $urandom_range(63)));
                else if (pick < 80)
                    push_request(random_req(REQ_LOAD));
                else if (pick < 93)
                    push_request(random_req(REQ_ORDER));
                else
                    push_request(random_req(REQ_UNUSED));
            end
            phase++;
        end

        // drain: every answer back, then a margin for stray beats
        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("crystal_symmetry_atom_mapper_tb: done, clean");
        end else begin
            $display("crystal_symmetry_atom_mapper_tb: done, errors");
        end
        $finish;
    end

endmodule
